FILE: rtl/deq_pkg.sv
// ============================================================================
// deq_pkg: shared types and constants of the double-ended queue unit
// Holds the queue depth, derived widths, opcode and error codes, the request
// and response payload structs and the controller command struct.
// ============================================================================
package deq_pkg;

   // Number of slots in the ring buffer.
   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int OP_W    = 3;
   localparam int OCC_W   = 5;
   localparam int ERR_W   = 2;

   // Opcodes. Codes above OP_QUERY behave as a query.
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
   localparam logic [ERR_W-1:0] ERR_POP_EMPTY = 2'd1;
   localparam logic [ERR_W-1:0] ERR_PUSH_FULL = 2'd2;

   // Value reported for front and back when the queue is empty.
   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = '1;

   typedef struct packed {
      logic [OP_W-1:0]           opcode;
      logic signed [VALUE_W-1:0] push_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] back_value;
      logic                      is_empty;
      logic                      is_full;
      logic [OCC_W-1:0]          occupancy;
      logic [ERR_W-1:0]          error_code;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;  // load the accepted request
      logic update;   // apply the operation to pointers, count and slots
      logic read;     // read the front and back slots
   } deq_cmd_type;

endpackage

FILE: rtl/deq_ram.sv
// ============================================================================
// deq_ram: generic RAM with one write port and two registered read ports
// Write and reads happen at the rising clock edge; read data is held while
// the read enable is low.
// ============================================================================
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                         rd_data_a,
   output logic [WIDTH-1:0]                         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: rtl/deq_ctrl.sv
// ============================================================================
// deq_ctrl: sequencing state machine of the double-ended queue unit
// Walks each request through capture, update, slot read and response.
// ============================================================================
module deq_ctrl
   import deq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output deq_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_UPDATE = 4'b0010,
      ST_READ   = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign cmd.capture = req_valid && (state_ff == ST_IDLE);
   assign cmd.update  = (state_ff == ST_UPDATE);
   assign cmd.read    = (state_ff == ST_READ);

endmodule

FILE: rtl/deq_datapath.sv
// ============================================================================
// deq_datapath: pointers, count and slot storage of the double-ended queue
// Applies one operation per update command and reads the front and back
// slots on a read command.
// ============================================================================
module deq_datapath
   import deq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  deq_cmd_type     cmd,
   input  req_payload_type req_payload,
   output rsp_payload_type rsp_payload
);

   logic [OP_W-1:0]    op_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [ERR_W-1:0]   err_ff;
   logic [ERR_W-1:0]   err_in;
   logic [IDX_W-1:0]   head_ff;
   logic [IDX_W-1:0]   head_in;
   logic [IDX_W-1:0]   tail_ff;
   logic [IDX_W-1:0]   tail_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   logic [IDX_W-1:0]   head_inc;
   logic [IDX_W-1:0]   head_dec;
   logic [IDX_W-1:0]   tail_inc;
   logic [IDX_W-1:0]   tail_dec;
   logic               q_empty;
   logic               q_full;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] rd_front;
   logic [VALUE_W-1:0] rd_back;
   logic [OCC_W+CNT_W-1:0] occ_ext;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - IDX_W'(1);
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + IDX_W'(1);
   assign tail_dec = (tail_ff == '0) ? LAST_IDX : tail_ff - IDX_W'(1);
   assign q_empty  = (count_ff == '0);
   assign q_full   = (count_ff == FULL_CNT);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      err_in   = ERR_OK;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      case (op_ff)
         OP_PUSH_FRONT: begin
            if (q_full) begin
               err_in = ERR_PUSH_FULL;
            end else begin
               head_in  = head_dec;
               wr_addr  = head_dec;
               wr_en    = 1'b1;
               count_in = count_ff + CNT_ONE;
            end
         end
         OP_PUSH_BACK: begin
            if (q_full) begin
               err_in = ERR_PUSH_FULL;
            end else begin
               tail_in  = tail_inc;
               wr_addr  = tail_ff;
               wr_en    = 1'b1;
               count_in = count_ff + CNT_ONE;
            end
         end
         OP_POP_FRONT: begin
            if (q_empty) begin
               err_in = ERR_POP_EMPTY;
            end else begin
               head_in  = head_inc;
               count_in = count_ff - CNT_ONE;
            end
         end
         OP_POP_BACK: begin
            if (q_empty) begin
               err_in = ERR_POP_EMPTY;
            end else begin
               tail_in  = tail_dec;
               count_in = count_ff - CNT_ONE;
            end
         end
         default: begin
            // Query and unused codes leave the queue as it is.
         end
      endcase
   end

   // Request payload and error code; no reset needed.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_payload.opcode;
         value_ff <= req_payload.push_value;
      end
      if (cmd.update) begin
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.update) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   deq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock     (clock),
      .wr_en     (wr_en && cmd.update),
      .wr_addr   (wr_addr),
      .wr_data   (value_ff),
      .rd_en     (cmd.read),
      .rd_addr_a (head_ff),
      .rd_addr_b (tail_dec),
      .rd_data_a (rd_front),
      .rd_data_b (rd_back)
   );

   assign occ_ext = {{OCC_W{1'b0}}, count_ff};

   assign rsp_payload.front_value = q_empty ? EMPTY_VALUE : $signed(rd_front);
   assign rsp_payload.back_value  = q_empty ? EMPTY_VALUE : $signed(rd_back);
   assign rsp_payload.is_empty    = q_empty;
   assign rsp_payload.is_full     = q_full;
   assign rsp_payload.occupancy   = occ_ext[OCC_W-1:0];
   assign rsp_payload.error_code  = err_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("element count exceeds the queue depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      q_full |-> (head_ff == tail_ff))
      else $error("full queue with head and tail apart");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && q_empty && ((op_ff == OP_POP_FRONT) || (op_ff == OP_POP_BACK)))
      |=> ((err_ff == ERR_POP_EMPTY) && q_empty))
      else $error("pop on empty queue not flagged or changed the count");
`endif

endmodule

FILE: rtl/double_ended_queue_unit.sv
// ============================================================================
// double_ended_queue_unit: bounded double-ended queue of signed 32-bit values
// Top level joining the sequencing controller and the ring-buffer datapath.
// ============================================================================
// Each request carries an opcode (push front, push back, pop front, pop back,
// or query; unused codes act as a query) and a value that only the pushes
// use, and produces exactly one response: the front and back values after
// the operation (all ones when the queue is empty), empty and full flags,
// the occupancy and an error code. A pop on an empty queue and a push on a
// full queue are flagged and leave the queue unchanged. The elements live in
// a DEPTH-entry ring buffer held in a small RAM with one write port and two
// registered read ports. One request is handled at a time: it is taken in
// the idle state, updates the pointers and writes its slot in the update
// state, reads the front and back slots through the registered RAM ports
// in the read state, and is then held as a response until rsp_ready takes
// it. req_ready returns only after the response is taken, so no new request
// is accepted while one is in flight; the RAM's registered read after the
// write is why a read state follows the update state. No clearing pass
// is needed after reset, since only slots that were written are ever
// reported.
module double_ended_queue_unit
   import deq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   deq_cmd_type cmd;

   // The controller sequences each request; the datapath holds all state
   // that the queue itself carries.
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   deq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule
